[rtl/core/srrw_pkg.sv]
// ----------------------------------------------------------------------------
// srrw_pkg: shared types and constants of the reorder window
// Window geometry, field widths and the control and result bundles of the
// shared sequence unit and the slot memory.
// ----------------------------------------------------------------------------
package srrw_pkg;

    localparam int WINDOW       = 8;
    localparam int PAYLOAD_BITS = 64;

    localparam int SEQ_W   = 31;
    localparam int PAY_W   = 64;
    localparam int TDATA_W = 96;
    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);

    localparam logic [PAY_W-1:0] PAY_MASK =
        (PAYLOAD_BITS >= PAY_W) ? {PAY_W{1'b1}}
                                : ((PAY_W'(1) << PAYLOAD_BITS) - PAY_W'(1));

    typedef enum logic {
        OP_DIST,
        OP_INC
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [SEQ_W-1:0]   a;
        logic [SEQ_W-1:0]   b;
        logic [SLOT_W-1:0]  head;
    } t_alu_ctrl;

    typedef struct packed {
        logic [SEQ_W-1:0]   sum;
        logic               zero;
        logic               in_win;
        logic [SLOT_W-1:0]  slot;
    } t_alu_res;

    typedef struct packed {
        logic               final_flag;
        logic [PAY_W-1:0]   payload;
    } t_slot_entry;

endpackage

[rtl/core/srrw_alu.sv]
// ----------------------------------------------------------------------------
// srrw_alu: shared sequence arithmetic unit
// One 31-bit adder used either for the window distance (seq - expected) or
// for the advance (expected + 1), plus the modular slot index beside it.
// ----------------------------------------------------------------------------
module srrw_alu (
    input  srrw_pkg::t_alu_ctrl i_ctrl,
    output srrw_pkg::t_alu_res  o_res
);
    import srrw_pkg::*;

    logic [SEQ_W-1:0]  w_sum;
    logic [SLOT_W-1:0] w_off;
    logic [SLOT_W:0]   w_slot_raw;
    logic [SLOT_W:0]   w_slot_wrap;

    always_comb begin
        case (i_ctrl.op)
            OP_DIST: begin
                w_sum = i_ctrl.a - i_ctrl.b;
                w_off = w_sum[SLOT_W-1:0];
            end
            OP_INC: begin
                w_sum = i_ctrl.a + SEQ_W'(1);
                w_off = SLOT_W'(1);
            end
            default: begin
                w_sum = i_ctrl.a;
                w_off = '0;
            end
        endcase
    end

    // both operands are below WINDOW, so one compare and subtract wraps
    assign w_slot_raw  = {1'b0, i_ctrl.head} + {1'b0, w_off};
    assign w_slot_wrap = (w_slot_raw >= (SLOT_W+1)'(WINDOW))
                       ? w_slot_raw - (SLOT_W+1)'(WINDOW) : w_slot_raw;

    assign o_res.sum    = w_sum;
    assign o_res.zero   = (w_sum == '0);
    assign o_res.in_win = (w_sum < SEQ_W'(WINDOW));
    assign o_res.slot   = w_slot_wrap[SLOT_W-1:0];

endmodule

[rtl/core/srrw_slot_mem.sv]
// ----------------------------------------------------------------------------
// srrw_slot_mem: buffered packet storage
// One entry per window slot holding payload and final flag; one write port
// and one read port with registered read data held until the next read.
// ----------------------------------------------------------------------------
module srrw_slot_mem (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [srrw_pkg::SLOT_W-1:0] i_wr_addr,
    input  srrw_pkg::t_slot_entry       i_wr_data,
    input  logic                        i_rd_en,
    input  logic [srrw_pkg::SLOT_W-1:0] i_rd_addr,
    output srrw_pkg::t_slot_entry       o_rd_data
);
    import srrw_pkg::*;

    t_slot_entry r_mem [WINDOW];
    t_slot_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/selective_repeat_reorder_window_top.sv]
// ----------------------------------------------------------------------------
// selective_repeat_reorder_window_top: selective-repeat receive window
// Takes received packets, buffers those ahead of the expected number and
// delivers packets in sequence order.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one received packet per beat: tdata holds the
//   sequence number and payload, tlast the final flag of the transfer.
//   Master stream carries delivered packets in order: tdata holds sequence
//   number and payload, tuser the final flag, tlast marks the last delivery
//   caused by one received packet.
//   A packet is taken only while the sequencer is idle. A packet that is
//   stored or dropped occupies the block for acceptance and the window test.
//   A packet that matches the expected number drives its first delivery
//   after the window test and S_EMIT0, then one buffered packet per cycle
//   from the slot memory while the receiver is ready, up to WINDOW
//   deliveries. The shared adder and the single slot memory read port
//   set that pace.
//   A stalled receiver holds the output register and freezes the drain.
//   Reset clears the window head, expected number, slot valid bits and the
//   finished flag. After a final packet is delivered, every beat is taken
//   and dropped.
// ----------------------------------------------------------------------------
module selective_repeat_reorder_window_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: seq_num[30:0], payload[94:31], zero pad[95]
    input  logic [srrw_pkg::TDATA_W-1:0] s_axis_tdata,
    // tlast: is_final
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tdata: out_seq[30:0], out_payload[94:31], zero pad[95]
    output logic [srrw_pkg::TDATA_W-1:0] m_axis_tdata,
    // tuser: out_final
    output logic                         m_axis_tuser,
    // tlast: last_of_run
    output logic                         m_axis_tlast
);
    import srrw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT0,
        S_DRAIN
    } t_state;

    t_state            r_state;
    logic [SEQ_W-1:0]  r_seq;
    logic [PAY_W-1:0]  r_pay;
    logic              r_fin;
    logic [SEQ_W-1:0]  r_exp;
    logic [SLOT_W-1:0] r_head;
    logic [WINDOW-1:0] r_full;
    logic              r_finished;
    logic [CNT_W-1:0]  r_k;
    logic              r_m_valid;
    logic [SEQ_W-1:0]  r_m_seq;
    logic [PAY_W-1:0]  r_m_pay;
    logic              r_m_final;
    logic              r_m_last;

    t_alu_ctrl   w_alu_ctrl;
    t_alu_res    w_alu_res;
    t_slot_entry w_wr_data;
    t_slot_entry w_rd_data;
    logic        w_wr_en;
    logic        w_rd_en;
    logic        w_in_fire;
    logic        w_out_free;
    logic        w_emit_fire;
    logic        w_emit_final;
    logic [PAY_W-1:0] w_emit_pay;
    logic [CNT_W-1:0] n_k;
    logic        n_stop;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_emit_fire   = ((r_state == S_EMIT0) || (r_state == S_DRAIN)) && w_out_free;

    always_comb begin
        w_alu_ctrl.op   = (r_state == S_EVAL) ? OP_DIST : OP_INC;
        w_alu_ctrl.a    = (r_state == S_EVAL) ? r_seq : r_exp;
        w_alu_ctrl.b    = r_exp;
        w_alu_ctrl.head = r_head;
    end

    srrw_alu u_alu (
        .i_ctrl (w_alu_ctrl),
        .o_res  (w_alu_res)
    );

    assign w_wr_en              = (r_state == S_EVAL) && w_alu_res.in_win && !w_alu_res.zero;
    assign w_wr_data.final_flag = r_fin;
    assign w_wr_data.payload    = r_pay;

    assign n_k          = r_k + CNT_W'(1);
    assign w_emit_final = (r_state == S_EMIT0) ? r_fin : w_rd_data.final_flag;
    assign w_emit_pay   = (r_state == S_EMIT0) ? r_pay : w_rd_data.payload;

    // stop on a final packet, a full window of deliveries or an empty next slot
    always_comb begin
        if (r_state == S_EMIT0) begin
            n_stop = r_fin || !r_full[w_alu_res.slot];
        end else begin
            n_stop = w_rd_data.final_flag || (n_k == CNT_W'(WINDOW))
                   || !r_full[w_alu_res.slot];
        end
    end

    // prefetch the next buffered packet while this beat is delivered
    assign w_rd_en = w_emit_fire && !n_stop;

    srrw_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_alu_res.slot),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_alu_res.slot),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_exp      <= '0;
            r_head     <= '0;
            r_full     <= '0;
            r_finished <= 1'b0;
            r_k        <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready && !w_emit_fire) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_seq <= s_axis_tdata[SEQ_W-1:0];
                        r_pay <= s_axis_tdata[SEQ_W+PAY_W-1:SEQ_W] & PAY_MASK;
                        r_fin <= s_axis_tlast;
                        // drop everything once the transfer is done
                        if (!r_finished) begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    if (w_alu_res.zero) begin
                        r_state <= S_EMIT0;
                    end else begin
                        if (w_alu_res.in_win) begin
                            r_full[w_alu_res.slot] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT0, S_DRAIN: begin
                    if (w_emit_fire) begin
                        r_m_valid        <= 1'b1;
                        r_m_seq          <= r_exp;
                        r_m_pay          <= w_emit_pay;
                        r_m_final        <= w_emit_final;
                        r_m_last         <= n_stop;
                        r_full[r_head]   <= 1'b0;
                        r_exp            <= w_alu_res.sum;
                        r_head           <= w_alu_res.slot;
                        r_k              <= (r_state == S_EMIT0) ? CNT_W'(1) : n_k;
                        if (n_stop) begin
                            r_finished <= w_emit_final;
                            r_state    <= S_IDLE;
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(TDATA_W-SEQ_W-PAY_W){1'b0}}, r_m_pay, r_m_seq};
    assign m_axis_tuser  = r_m_final;
    assign m_axis_tlast  = r_m_last;

    a_drain_slot_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> r_full[r_head])
        else $error("drain reached an empty slot");

    a_drain_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> ((r_k != '0) && (r_k < CNT_W'(WINDOW))))
        else $error("drain count out of range");

    a_final_ends_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("final delivery not marked as last of run");

    a_finished_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> (r_finished && (r_state == S_IDLE)))
        else $error("block left finished state");

    a_no_store_after_final : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> $stable(r_full))
        else $error("slot valid bits changed after finish");

endmodule
